>>> rtl/core/falc_pkg.sv
// Shared constants, types and codes for the flash append log controller.
// No dependencies; every module of the block imports this package.
package falc_pkg;

    localparam int PAGE_BYTES     = 64;
    localparam int PAGE_COUNT     = 96;
    localparam int WORDS_PER_PAGE = PAGE_BYTES / 2;
    localparam int HDR_WORDS      = (WORDS_PER_PAGE + 15) / 16;
    localparam int HDR_BITS       = HDR_WORDS * 16;
    localparam int NO_PAGE        = PAGE_COUNT;

    localparam int ADDR_W     = 13;
    localparam int DATA_W     = 16;
    localparam int PAGE_W     = $clog2(PAGE_COUNT + 1);
    localparam int PAGE_IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int SLOT_W     = $clog2(WORDS_PER_PAGE);
    localparam int HDR_IDX_W  = (HDR_WORDS > 1) ? $clog2(HDR_WORDS) : 1;

    typedef logic [2:0]                t_mode;
    typedef logic [1:0]                t_cmd;
    typedef logic [2:0]                t_status;
    typedef logic [WORDS_PER_PAGE-1:0] t_bitmap;
    typedef logic [PAGE_IDX_W-1:0]     t_page_idx;
    typedef logic [PAGE_W-1:0]         t_page;
    typedef logic [SLOT_W-1:0]         t_slot;

    localparam t_mode MODE_OPEN  = 3'd0;
    localparam t_mode MODE_WRITE = 3'd1;
    localparam t_mode MODE_CLOSE = 3'd2;
    localparam t_mode MODE_ERASE = 3'd3;

    localparam t_cmd CMD_STATUS  = 2'd0;
    localparam t_cmd CMD_FILL    = 2'd1;
    localparam t_cmd CMD_PROGRAM = 2'd2;
    localparam t_cmd CMD_ERASE   = 2'd3;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BUSY        = 3'd1;
    localparam t_status ST_NOSPACE     = 3'd2;
    localparam t_status ST_UNSUPPORTED = 3'd3;
    localparam t_status ST_NOTOPEN     = 3'd4;

endpackage

>>> rtl/core/falc_bitmap_ram.sv
// Header bitmap mirror: one bitmap per page, registered read, one port.
// Uses falc_pkg; per-page valid bits make unwritten or erased pages read all ones.
module falc_bitmap_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_erase,
    input  logic                i_wr_en,
    input  falc_pkg::t_page_idx i_addr,
    input  falc_pkg::t_bitmap   i_wr_data,
    output falc_pkg::t_bitmap   o_rd_data
);
    import falc_pkg::*;

    t_bitmap               r_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_valid;
    t_bitmap               r_rd_word;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_erase) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_word  <= r_mem[i_addr];
        r_rd_valid <= r_valid[i_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_word : '1;

endmodule

>>> rtl/core/falc_slot_find.sv
// Lowest free data slot of one page bitmap, header slots skipped.
// Uses falc_pkg; shared by the open scan over all pages.
module falc_slot_find (
    input  falc_pkg::t_bitmap i_bitmap,
    output logic              o_found,
    output falc_pkg::t_slot   o_slot
);
    import falc_pkg::*;

    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        // walk down so the lowest free slot wins
        for (int i = WORDS_PER_PAGE - 1; i >= HDR_WORDS; i--) begin
            if (i_bitmap[i]) begin
                o_found = 1'b1;
                o_slot  = SLOT_W'(i);
            end
        end
    end

endmodule

>>> rtl/core/flash_append_log_controller.sv
// Top level of the flash append log controller: command sequencer and result register.
// Uses falc_pkg, falc_bitmap_ram and falc_slot_find.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  command  | start, busy            | i_mode, i_data_word, i_last_word
//  result   | o_strobe (one cycle)   | o_command, o_flash_address, o_fill_word,
//           |                        | o_status, o_last_result
//
// An item is taken at an edge with start high and busy low; busy stays high until
// its last result is registered. Status-only and erase items answer straight from idle.
// A write reads the bitmap, updates it and gives the fill result, then issues the header
// fills and the program when the page is full or the word is the last; when a full
// page is followed by a flush of the page just opened, its bitmap is reloaded first.
// A close with an open page reloads its bitmap, then issues the header fills and program.
// Open walks the bitmap memory one page at a time up to the first page with a free slot.
// Reset is synchronous; the bitmap mirror needs no clearing pass (valid bits per page).
// Results are shown for exactly one cycle and cannot be stalled by the receiver.
module flash_append_log_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  falc_pkg::t_mode             i_mode,
    input  logic [falc_pkg::DATA_W-1:0] i_data_word,
    input  logic                        i_last_word,
    output logic                        o_strobe,
    output falc_pkg::t_cmd              o_command,
    output logic [falc_pkg::ADDR_W-1:0] o_flash_address,
    output logic [falc_pkg::DATA_W-1:0] o_fill_word,
    output falc_pkg::t_status           o_status,
    output logic                        o_last_result
);
    import falc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_ADDR,
        S_SCAN_EVAL,
        S_WR_ADDR,
        S_WR_EVAL,
        S_LD_ADDR,
        S_LD_EVAL,
        S_HDR,
        S_PROG,
        S_CLOSE
    } t_state;

    // what follows the page program of a flush
    typedef enum logic [1:0] {
        CONT_DONE,
        CONT_NEXT,
        CONT_CLOSE
    } t_cont;

    function automatic logic [ADDR_W-1:0] page_base(input t_page_idx page);
        return ADDR_W'(page * PAGE_BYTES);
    endfunction

    // control registers
    t_state                 r_state, n_state;
    t_cont                  r_cont, n_cont;
    logic                   r_log_open, n_log_open;
    t_page                  r_cur_page, n_cur_page;
    t_slot                  r_slot, n_slot;
    t_page_idx              r_page, n_page;
    logic [HDR_IDX_W-1:0]   r_hdr, n_hdr;
    logic                   r_strobe, n_strobe;
    // payload registers
    t_bitmap                r_bm, n_bm;
    logic [DATA_W-1:0]      r_data, n_data;
    logic                   r_last_in, n_last_in;
    t_cmd                   r_command, n_command;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [DATA_W-1:0]      r_fill, n_fill;
    t_status                r_status, n_status;
    logic                   r_last_res, n_last_res;

    logic                   mem_wr_en;
    logic                   mem_erase;
    t_bitmap                rd_bm;
    t_bitmap                bm_new;
    logic                   scan_found;
    t_slot                  scan_slot;
    logic [HDR_BITS-1:0]    hdr_bits;

    falc_bitmap_ram u_bitmap_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_erase   (mem_erase),
        .i_wr_en   (mem_wr_en),
        .i_addr    (r_page),
        .i_wr_data (bm_new),
        .o_rd_data (rd_bm)
    );

    falc_slot_find u_slot_find (
        .i_bitmap (rd_bm),
        .o_found  (scan_found),
        .o_slot   (scan_slot)
    );

    // clear the bit of the word being written
    assign bm_new = rd_bm & ~(t_bitmap'(1) << r_slot);

    // pad the bitmap to whole header words; bits past the page read as erased
    always_comb begin
        hdr_bits                     = '1;
        hdr_bits[WORDS_PER_PAGE-1:0] = r_bm;
    end

    always_comb begin
        n_state    = r_state;
        n_cont     = r_cont;
        n_log_open = r_log_open;
        n_cur_page = r_cur_page;
        n_slot     = r_slot;
        n_page     = r_page;
        n_hdr      = r_hdr;
        n_bm       = r_bm;
        n_data     = r_data;
        n_last_in  = r_last_in;
        n_strobe   = 1'b0;
        n_command  = CMD_STATUS;
        n_addr     = '0;
        n_fill     = '0;
        n_status   = ST_OK;
        n_last_res = 1'b0;
        mem_wr_en  = 1'b0;
        mem_erase  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_data    = i_data_word;
                    n_last_in = i_last_word;
                    n_strobe  = 1'b1;
                    n_last_res = 1'b1;
                    case (i_mode)
                        MODE_OPEN: begin
                            if (r_log_open) begin
                                n_status = ST_BUSY;
                            end else begin
                                // scan from page 0; result comes at end of scan
                                n_strobe   = 1'b0;
                                n_last_res = 1'b0;
                                n_log_open = 1'b1;
                                n_cur_page = PAGE_W'(NO_PAGE);
                                n_slot     = SLOT_W'(HDR_WORDS);
                                n_page     = '0;
                                n_state    = S_SCAN_ADDR;
                            end
                        end
                        MODE_WRITE: begin
                            if (!r_log_open) begin
                                n_status = ST_NOTOPEN;
                            end else if (r_cur_page == PAGE_W'(NO_PAGE)) begin
                                n_status = ST_NOSPACE;
                            end else begin
                                n_strobe   = 1'b0;
                                n_last_res = 1'b0;
                                n_page     = r_cur_page[PAGE_IDX_W-1:0];
                                n_state    = S_WR_ADDR;
                            end
                        end
                        MODE_CLOSE: begin
                            if (!r_log_open) begin
                                n_status = ST_NOTOPEN;
                            end else begin
                                n_log_open = 1'b0;
                                n_cur_page = PAGE_W'(NO_PAGE);
                                n_slot     = SLOT_W'(HDR_WORDS);
                                if (r_cur_page != PAGE_W'(NO_PAGE)) begin
                                    // flush the open page, then report ok
                                    n_strobe   = 1'b0;
                                    n_last_res = 1'b0;
                                    n_page     = r_cur_page[PAGE_IDX_W-1:0];
                                    n_cont     = CONT_CLOSE;
                                    n_state    = S_LD_ADDR;
                                end
                            end
                        end
                        MODE_ERASE: begin
                            if (r_log_open) begin
                                n_status = ST_BUSY;
                            end else begin
                                mem_erase = 1'b1;
                                n_command = CMD_ERASE;
                            end
                        end
                        default: begin
                            n_status = ST_UNSUPPORTED;
                        end
                    endcase
                end
            end

            S_SCAN_ADDR: begin
                n_state = S_SCAN_EVAL;
            end

            S_SCAN_EVAL: begin
                if (scan_found) begin
                    n_cur_page = PAGE_W'(r_page);
                    n_slot     = scan_slot;
                    n_strobe   = 1'b1;
                    n_last_res = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_page == PAGE_IDX_W'(PAGE_COUNT - 1)) begin
                    // no free word anywhere: open with no page
                    n_strobe   = 1'b1;
                    n_last_res = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_page  = r_page + PAGE_IDX_W'(1);
                    n_state = S_SCAN_ADDR;
                end
            end

            S_WR_ADDR: begin
                n_state = S_WR_EVAL;
            end

            S_WR_EVAL: begin
                mem_wr_en = 1'b1;
                n_bm      = bm_new;
                n_strobe  = 1'b1;
                n_command = CMD_FILL;
                n_addr    = page_base(r_page) + ADDR_W'({r_slot, 1'b0});
                n_fill    = r_data;
                n_hdr     = '0;
                n_cont    = CONT_DONE;
                if (r_slot == SLOT_W'(WORDS_PER_PAGE - 1)) begin
                    // page full: flush it, advance to the next page if any
                    n_slot  = SLOT_W'(HDR_WORDS);
                    n_state = S_HDR;
                    if (r_page == PAGE_IDX_W'(PAGE_COUNT - 1)) begin
                        n_cur_page = PAGE_W'(NO_PAGE);
                    end else begin
                        n_cur_page = r_cur_page + PAGE_W'(1);
                        if (r_last_in) begin
                            n_cont = CONT_NEXT;
                        end
                    end
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                    if (r_last_in) begin
                        n_state = S_HDR;
                    end else begin
                        n_last_res = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end

            S_LD_ADDR: begin
                n_state = S_LD_EVAL;
            end

            S_LD_EVAL: begin
                n_bm    = rd_bm;
                n_hdr   = '0;
                n_state = S_HDR;
            end

            S_HDR: begin
                n_strobe  = 1'b1;
                n_command = CMD_FILL;
                n_addr    = page_base(r_page) + ADDR_W'({r_hdr, 1'b0});
                n_fill    = hdr_bits[16*r_hdr +: 16];
                if (r_hdr == HDR_IDX_W'(HDR_WORDS - 1)) begin
                    n_state = S_PROG;
                end else begin
                    n_hdr = r_hdr + HDR_IDX_W'(1);
                end
            end

            S_PROG: begin
                n_strobe  = 1'b1;
                n_command = CMD_PROGRAM;
                n_addr    = page_base(r_page);
                case (r_cont)
                    CONT_NEXT: begin
                        // last word filled the page: flush the page just opened
                        n_page  = r_cur_page[PAGE_IDX_W-1:0];
                        n_cont  = CONT_DONE;
                        n_state = S_LD_ADDR;
                    end
                    CONT_CLOSE: begin
                        n_state = S_CLOSE;
                    end
                    default: begin
                        n_last_res = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end

            S_CLOSE: begin
                n_strobe   = 1'b1;
                n_last_res = 1'b1;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cont     <= CONT_DONE;
            r_log_open <= 1'b0;
            r_cur_page <= PAGE_W'(NO_PAGE);
            r_slot     <= SLOT_W'(HDR_WORDS);
            r_page     <= '0;
            r_hdr      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cont     <= n_cont;
            r_log_open <= n_log_open;
            r_cur_page <= n_cur_page;
            r_slot     <= n_slot;
            r_page     <= n_page;
            r_hdr      <= n_hdr;
            r_strobe   <= n_strobe;
        end
        r_bm       <= n_bm;
        r_data     <= n_data;
        r_last_in  <= n_last_in;
        r_command  <= n_command;
        r_addr     <= n_addr;
        r_fill     <= n_fill;
        r_status   <= n_status;
        r_last_res <= n_last_res;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_command       = r_command;
    assign o_flash_address = r_addr;
    assign o_fill_word     = r_fill;
    assign o_status        = r_status;
    assign o_last_result   = r_last_res;

    // a closed log never holds a page
    a_closed_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_log_open |-> (r_cur_page == PAGE_W'(NO_PAGE)))
        else $error("closed log holds a page");

    // the current page is a real page or the no-page mark
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_page <= PAGE_W'(NO_PAGE))
        else $error("current page out of range");

    // the next slot never points into the header
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot >= SLOT_W'(HDR_WORDS))
        else $error("next slot inside header");

    // an unsupported mode answers in the next cycle with one final status
    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode != MODE_OPEN && i_mode != MODE_WRITE &&
         i_mode != MODE_CLOSE && i_mode != MODE_ERASE)
        |=> (o_strobe && o_status == ST_UNSUPPORTED && o_last_result))
        else $error("unsupported mode not reported");

    // an erase command is always a single final ok result
    a_erase_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_command == CMD_ERASE) |-> (o_status == ST_OK && o_last_result))
        else $error("erase result malformed");

endmodule
